// ----- rtl/qbd_pkg.sv -----
package qbd_pkg;

    localparam int BLOCK_BUFFER_BYTES_DEF = 210;

    localparam logic [1:0] FMT_Q8_0 = 2'd0;
    localparam logic [1:0] FMT_Q5_K = 2'd1;
    localparam logic [1:0] FMT_Q6_K = 2'd2;

    localparam logic [0:0] REG_QUANT_FORMAT = 1'b0;
    localparam logic [0:0] REG_ROW_BLOCKS   = 1'b1;

    // last byte offset of each block layout
    localparam logic [7:0] Q8_LAST_BYTE = 8'd33;
    localparam logic [7:0] Q5_LAST_BYTE = 8'd175;
    localparam logic [7:0] Q6_LAST_BYTE = 8'd209;

    localparam logic [4:0]  K_LAST_GROUP   = 5'd31;
    localparam logic [4:0]  Q8_LAST_GROUP  = 5'd3;
    localparam logic [12:0] ROW_BLOCKS_MAX = 13'd4096;
    localparam logic [31:0] CANON_NAN      = 32'h7FC0_0000;
    localparam logic [8:0]  EXP_OFFSET     = 9'd103;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    // per-element tag travelling down the conversion pipeline
    typedef struct packed {
        logic       valid;
        logic [2:0] lane;
        logic       nan;
        logic       inf;
        logic       sgn;
    } tag_t;

endpackage

// ----- rtl/quantized_block_dequantizer.sv -----
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | packed_byte
// output   | out_valid / out_ready  | lane_0..lane_7, element_index, last_of_block,
//          |                        | last_of_row
// config   | cfg_we                 | cfg_index, cfg_data
//
// one byte transaction per cycle while a block loads and cfg_we is low; the byte
// that completes a block starts the decode, and no byte is taken until all its
// groups are out; each group of eight issues one element a cycle over the two
// read ports of the block buffer, then passes down the conversion pipeline to
// fp32, and the next group issues only once out_ready has taken this one
// reset clears the control state only; the block buffer holds garbage until filled
module quantized_block_dequantizer
    import qbd_pkg::*;
#(
    parameter int BLOCK_BUFFER_BYTES = BLOCK_BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  packed_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] lane_0,
    output logic [31:0] lane_1,
    output logic [31:0] lane_2,
    output logic [31:0] lane_3,
    output logic [31:0] lane_4,
    output logic [31:0] lane_5,
    output logic [31:0] lane_6,
    output logic [31:0] lane_7,
    output logic [19:0] element_index,
    output logic        last_of_block,
    output logic        last_of_row,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int AW = $clog2(BLOCK_BUFFER_BYTES);

    // configuration and sequencing
    logic [1:0]  fmt_reg;
    logic [12:0] rows_reg;
    logic [7:0]  pos_reg;
    logic [11:0] blk_reg;
    state_t      state_reg;
    logic [7:0]  e_reg;
    logic [19:0] base_reg;
    logic        row_end_reg;

    // header fields captured as the bytes go by
    logic [15:0] hdr_d_reg;
    logic [15:0] hdr_m_reg;
    logic [7:0]  sbyte_reg [16];

    // block buffer
    logic [7:0]  buf_mem [BLOCK_BUFFER_BYTES];
    logic [7:0]  rd_lo_reg;
    logic [7:0]  rd_hb_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] lanes_reg [8];
    logic [19:0] idx_reg;
    logic        lob_reg;
    logic        lor_reg;

    logic is_q5, is_q6, is_k;
    logic in_acc, out_acc;
    logic [7:0]  last_pos;
    logic [12:0] blocks_eff;
    logic        row_end;
    logic [4:0]  grp_last;

    assign is_q5 = (fmt_reg == FMT_Q5_K);
    assign is_q6 = (fmt_reg == FMT_Q6_K);
    assign is_k  = is_q5 | is_q6;
    assign last_pos = is_q5 ? Q5_LAST_BYTE : (is_q6 ? Q6_LAST_BYTE : Q8_LAST_BYTE);
    assign grp_last = is_k ? K_LAST_GROUP : Q8_LAST_GROUP;

    always_comb
    begin
        if (rows_reg == 13'd0)
            blocks_eff = 13'd1;
        else if (rows_reg > ROW_BLOCKS_MAX)
            blocks_eff = ROW_BLOCKS_MAX;
        else
            blocks_eff = rows_reg;
    end

    // a register write takes the cycle, no byte goes in alongside it
    assign row_end  = ({1'b0, blk_reg} + 13'd1) >= blocks_eff;
    assign in_ready = (state_reg == ST_IDLE) & ~cfg_we;
    assign in_acc   = in_valid & in_ready;
    assign out_acc  = out_valid_reg & out_ready;

    // fp16 header decode: value = mant * 2^(exp - 24)
    logic [10:0] md, mm;
    logic [4:0]  ed, em, emin;
    logic        dnan, dinf, mnan, minf;

    assign md   = {(hdr_d_reg[14:10] != 5'd0), hdr_d_reg[9:0]};
    assign mm   = {(hdr_m_reg[14:10] != 5'd0), hdr_m_reg[9:0]};
    assign ed   = (hdr_d_reg[14:10] == 5'd0) ? 5'd0 : hdr_d_reg[14:10] - 5'd1;
    assign em   = (hdr_m_reg[14:10] == 5'd0) ? 5'd0 : hdr_m_reg[14:10] - 5'd1;
    assign emin = (is_q5 && em < ed) ? em : ed;
    assign dnan = (hdr_d_reg[14:10] == 5'd31) && (hdr_d_reg[9:0] != 10'd0);
    assign dinf = (hdr_d_reg[14:10] == 5'd31) && (hdr_d_reg[9:0] == 10'd0);
    assign mnan = (hdr_m_reg[14:10] == 5'd31) && (hdr_m_reg[9:0] != 10'd0);
    assign minf = (hdr_m_reg[14:10] == 5'd31) && (hdr_m_reg[9:0] == 10'd0);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= FMT_Q8_0;
            rows_reg    <= 13'd1;
            pos_reg     <= 8'd0;
            blk_reg     <= 12'd0;
            state_reg   <= ST_IDLE;
            e_reg       <= 8'd0;
            base_reg    <= 20'd0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUANT_FORMAT: fmt_reg  <= cfg_data[1:0];
                    REG_ROW_BLOCKS:   rows_reg <= cfg_data;
                    default:          rows_reg <= cfg_data;
                endcase
                pos_reg <= 8'd0;
                blk_reg <= 12'd0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (pos_reg == last_pos)
                        begin
                            pos_reg     <= 8'd0;
                            state_reg   <= ST_ISSUE;
                            e_reg       <= 8'd0;
                            base_reg    <= is_k ? {blk_reg, 8'd0} : {3'd0, blk_reg, 5'd0};
                            row_end_reg <= row_end;
                            blk_reg     <= row_end ? 12'd0 : blk_reg + 12'd1;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 8'd1;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    e_reg <= e_reg + 8'd1;
                    if (e_reg[2:0] == 3'd7)
                        state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (out_acc)
                        state_reg <= lob_reg ? ST_IDLE : ST_ISSUE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // buffer write and header capture
    logic [7:0] pos_q5s;
    assign pos_q5s = pos_reg - 8'd4;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            buf_mem[pos_reg[AW-1:0]] <= packed_byte;
            if (pos_reg == 8'd0 && !is_q6)
                hdr_d_reg[7:0] <= packed_byte;
            if (pos_reg == 8'd1 && !is_q6)
                hdr_d_reg[15:8] <= packed_byte;
            if (is_q5 && pos_reg == 8'd2)
                hdr_m_reg[7:0] <= packed_byte;
            if (is_q5 && pos_reg == 8'd3)
                hdr_m_reg[15:8] <= packed_byte;
            if (is_q5 && pos_reg >= 8'd4 && pos_reg <= 8'd15)
                sbyte_reg[pos_q5s[3:0]] <= packed_byte;
            if (is_q6 && pos_reg >= 8'd192 && pos_reg <= 8'd207)
                sbyte_reg[pos_reg[3:0]] <= packed_byte;
            if (is_q6 && pos_reg == 8'd208)
                hdr_d_reg[7:0] <= packed_byte;
            if (is_q6 && pos_reg == 8'd209)
                hdr_d_reg[15:8] <= packed_byte;
        end
    end

    // stage 0: element addresses and scales
    logic [7:0] lo_addr, hb_addr;
    logic [5:0] sc5 [8];
    logic [5:0] mn5 [8];
    logic [7:0] sc0;
    logic [5:0] mn0;

    always_comb
    begin
        if (is_q5)
        begin
            lo_addr = 8'd48 + {1'b0, e_reg[7:6], e_reg[4:0]};
            hb_addr = 8'd16 + {3'd0, e_reg[4:0]};
        end
        else if (is_q6)
        begin
            lo_addr = {1'b0, e_reg[7], e_reg[5], e_reg[4:0]};
            hb_addr = 8'd128 + {2'd0, e_reg[7], e_reg[4:0]};
        end
        else
        begin
            lo_addr = 8'd2 + {3'd0, e_reg[4:0]};
            hb_addr = lo_addr;
        end
    end

    // six-bit scale and minimum layout of the Q5_K header
    for (genvar k = 0; k < 8; k++)
    begin : g_q5_scale
        if (k < 4)
        begin : g_lo
            assign sc5[k] = sbyte_reg[k][5:0];
            assign mn5[k] = sbyte_reg[k + 4][5:0];
        end
        else
        begin : g_hi
            assign sc5[k] = {sbyte_reg[k - 4][7:6], sbyte_reg[k + 4][3:0]};
            assign mn5[k] = {sbyte_reg[k][7:6], sbyte_reg[k + 4][7:4]};
        end
    end

    always_comb
    begin
        if (is_q5)
        begin
            sc0 = {2'd0, sc5[e_reg[7:5]]};
            mn0 = mn5[e_reg[7:5]];
        end
        else if (is_q6)
        begin
            sc0 = sbyte_reg[e_reg[7:4]];
            mn0 = 6'd0;
        end
        else
        begin
            sc0 = 8'd1;
            mn0 = 6'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_lo_reg <= buf_mem[lo_addr[AW-1:0]];
        rd_hb_reg <= buf_mem[hb_addr[AW-1:0]];
    end

    tag_t       t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [2:0] e1_reg;
    logic [7:0] sc1_reg;
    logic [5:0] mn1_reg;

    // stage 1: quant value, scale products, special values
    logic [3:0]         nib5, nib6;
    logic [7:0]         hsh5, hsh6;
    logic signed [8:0]  qv1;
    logic signed [19:0] fa1;
    logic [16:0]        fb1;
    logic               qz, qneg, scz, scneg, mnz;
    logic               a_nan, a_inf, a_sg, b_nan, b_inf;
    tag_t               t1_next;

    assign nib5 = e1_reg[0] ? rd_lo_reg[7:4] : rd_lo_reg[3:0];
    assign nib6 = e1_reg[1] ? rd_lo_reg[7:4] : rd_lo_reg[3:0];
    assign hsh5 = rd_hb_reg >> e1_reg;
    assign hsh6 = rd_hb_reg >> {e1_reg[1:0], 1'b0};

    always_comb
    begin
        if (is_q5)
            qv1 = {4'd0, hsh5[0], nib5};
        else if (is_q6)
            qv1 = {3'd0, hsh6[1:0], nib6} - 9'sd32;
        else
            qv1 = {rd_lo_reg[7], rd_lo_reg};
    end

    assign fa1   = $signed(sc1_reg) * $signed({1'b0, md});
    assign fb1   = mn1_reg * mm;
    assign qz    = (qv1 == 9'sd0);
    assign qneg  = qv1[8];
    assign scz   = (sc1_reg == 8'd0);
    assign scneg = sc1_reg[7];
    assign mnz   = (mn1_reg == 6'd0);
    assign a_nan = dnan | (dinf & (scz | qz));
    assign a_inf = dinf & ~scz & ~qz;
    assign a_sg  = hdr_d_reg[15] ^ scneg ^ qneg;
    assign b_nan = mnan | (minf & mnz);
    assign b_inf = minf & ~mnz;

    always_comb
    begin
        t1_next = t1_reg;
        if (is_q5)
        begin
            t1_next.nan = a_nan | b_nan | (a_inf & b_inf & (a_sg == hdr_m_reg[15]));
            t1_next.inf = a_inf | b_inf;
            if (a_inf | b_inf)
                t1_next.sgn = a_inf ? a_sg : ~hdr_m_reg[15];
            else
                t1_next.sgn = (qz | scz | md == 11'd0) & (mnz | mm == 11'd0)
                              & hdr_d_reg[15] & ~hdr_m_reg[15];
        end
        else
        begin
            t1_next.nan = a_nan;
            t1_next.inf = a_inf;
            t1_next.sgn = a_sg;
        end
    end

    // stage 2 registers
    logic signed [8:0]  qv2_reg;
    logic signed [19:0] fa2_reg;
    logic [16:0]        fb2_reg;

    // stage 2: element product and signed terms
    logic signed [28:0] pa2;
    logic signed [28:0] a3_reg;
    logic signed [17:0] b3_reg;

    assign pa2 = qv2_reg * fa2_reg;

    // stage 3: align the two terms and subtract
    logic [4:0]          sha, shb;
    logic signed [55:0]  s3;
    logic [54:0]         mag4_reg;
    logic                neg4_reg;

    assign sha = ed - emin;
    assign shb = is_q5 ? em - emin : 5'd0;
    assign s3  = ({{27{a3_reg[28]}}, a3_reg} <<< sha) - ({{38{b3_reg[17]}}, b3_reg} <<< shb);

    logic signed [55:0] s4_reg;
    logic [55:0]        abs4;
    logic [5:0]         p4;

    assign abs4 = s4_reg[55] ? -s4_reg : s4_reg;

    // leading one of the magnitude
    always_comb
    begin
        p4 = 6'd0;
        for (int i = 0; i < 55; i++)
        begin
            if (abs4[i])
                p4 = 6'(i);
        end
    end

    logic [5:0] p5_reg;

    // stage 5: normalise and round to nearest even
    logic [54:0] norm5;
    logic [23:0] mant5;
    logic        up5;
    logic [24:0] m25;
    logic [8:0]  exp5;
    logic [31:0] bits5;

    assign norm5 = mag4_reg << (6'd54 - p5_reg);
    assign mant5 = norm5[54:31];
    assign up5   = norm5[30] & ((|norm5[29:0]) | mant5[0]);
    assign m25   = {1'b0, mant5} + {24'd0, up5};
    assign exp5  = {3'd0, p5_reg} + {4'd0, emin} + EXP_OFFSET + {8'd0, m25[24]};

    always_comb
    begin
        if (t5_reg.nan)
            bits5 = CANON_NAN;
        else if (t5_reg.inf)
            bits5 = {t5_reg.sgn, 8'hFF, 23'd0};
        else if (mag4_reg == 55'd0)
            bits5 = {t5_reg.sgn, 31'd0};
        else
            bits5 = {neg4_reg, exp5[7:0], m25[24] ? 23'd0 : m25[22:0]};
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else
        begin
            t1_reg.valid <= (state_reg == ST_ISSUE);
            t1_reg.lane  <= e_reg[2:0];
            t2_reg       <= t1_next;
            t3_reg       <= t2_reg;
            t4_reg       <= t3_reg;
            t5_reg       <= t4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg   <= e_reg[7:5];
        sc1_reg  <= sc0;
        mn1_reg  <= mn0;
        qv2_reg  <= qv1;
        fa2_reg  <= fa1;
        fb2_reg  <= fb1;
        a3_reg   <= hdr_d_reg[15] ? -pa2 : pa2;
        if (is_q5)
            b3_reg <= hdr_m_reg[15] ? -$signed({1'b0, fb2_reg}) : $signed({1'b0, fb2_reg});
        else
            b3_reg <= 18'sd0;
        s4_reg   <= s3;
        mag4_reg <= abs4[54:0];
        neg4_reg <= s4_reg[55];
        p5_reg   <= p4;
        if (t5_reg.valid)
            lanes_reg[t5_reg.lane] <= bits5;
        if (state_reg == ST_ISSUE && e_reg[2:0] == 3'd0)
        begin
            idx_reg <= base_reg + {12'd0, e_reg[7:3], 3'd0};
            lob_reg <= (e_reg[7:3] == grp_last);
            lor_reg <= (e_reg[7:3] == grp_last) & row_end_reg;
        end
    end

    // a group is complete when its eighth lane lands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (t5_reg.valid && t5_reg.lane == 3'd7)
            out_valid_reg <= 1'b1;
        else if (out_acc)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign lane_0        = lanes_reg[0];
    assign lane_1        = lanes_reg[1];
    assign lane_2        = lanes_reg[2];
    assign lane_3        = lanes_reg[3];
    assign lane_4        = lanes_reg[4];
    assign lane_5        = lanes_reg[5];
    assign lane_6        = lanes_reg[6];
    assign lane_7        = lanes_reg[7];
    assign element_index = idx_reg;
    assign last_of_block = lob_reg;
    assign last_of_row   = lor_reg;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import qbd_pkg::*;

    // one decoded group of eight weights
    typedef struct {
        logic [31:0] lane [8];
        logic [19:0] index;
        logic        block_end;
        logic        row_end;
    } weight_group_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  packed_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7;
    logic [19:0] element_index;
    logic        last_of_block;
    logic        last_of_row;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [12:0] cfg_data;

    // predictor state, mirrors the block
    logic [7:0]  blk_buf [210];
    int unsigned fill_pos;
    logic [11:0] blk_num;
    logic [1:0]  cur_fmt;
    logic [12:0] cur_rows;

    logic [7:0]    pending_bytes [$];
    weight_group_t expected_groups [$];
    int            mismatch_count;

    // stimulus shaping shared with the driver and monitor
    bit          no_idle;
    bit          long_hold_req;
    bit          long_hold_used;
    int          hold_left;
    int          tx_gap;
    int          rx_gap;
    int          quiet_cycles;

    quantized_block_dequantizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packed_byte   (packed_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lane_0        (lane_0),
        .lane_1        (lane_1),
        .lane_2        (lane_2),
        .lane_3        (lane_3),
        .lane_4        (lane_4),
        .lane_5        (lane_5),
        .lane_6        (lane_6),
        .lane_7        (lane_7),
        .element_index (element_index),
        .last_of_block (last_of_block),
        .last_of_row   (last_of_row),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fp16 at buffer offset, little-endian, converted exactly to a real
    function automatic real fp16_at(int unsigned ofs);
        logic [15:0] h;
        real         r;
        h = {blk_buf[ofs + 1], blk_buf[ofs]};
        if (h[14:10] == 5'd0)
        begin
            if (h[9:0] == 10'd0)
                r = $bitstoreal({h[15], 63'd0});
            else
            begin
                r = $itor(h[9:0]) * (2.0 ** (-24));
                if (h[15])
                    r = -r;
            end
        end
        else if (h[14:10] == 5'd31)
            r = $bitstoreal(h[9:0] == 10'd0 ? {h[15], 11'h7FF, 52'd0} : 64'h7FF8_0000_0000_0000);
        else
            r = $bitstoreal({h[15], 11'(h[14:10] - 15 + 1023), h[9:0], 42'd0});
        return r;
    endfunction

    // round a real to fp32 bits, nearest even, NaN made canonical
    function automatic logic [31:0] fp32_bits(real x);
        logic [63:0] b;
        logic [52:0] mant;
        logic [24:0] kept;
        int          ex;
        b = $realtobits(x);
        if (b[62:52] == 11'h7FF)
            return (b[51:0] != 0) ? CANON_NAN : {b[63], 8'hFF, 23'd0};
        if (b[62:0] == 63'd0)
            return {b[63], 31'd0};
        ex   = int'(b[62:52]) - 1023 + 127;
        mant = {1'b1, b[51:0]};
        kept = {1'b0, mant[52:29]};
        if (mant[28] && (mant[27:0] != 0 || kept[0]))
            kept = kept + 1;
        if (kept[24])
        begin
            kept = kept >> 1;
            ex   = ex + 1;
        end
        if (ex >= 255)
            return {b[63], 8'hFF, 23'd0};
        if (ex <= 0)
            return {b[63], 31'd0};
        return {b[63], 8'(ex), kept[22:0]};
    endfunction

    function automatic real int8_value(logic [7:0] v);
        return $itor($signed(v));
    endfunction

    function automatic real q5_weight(int unsigned e);
        int unsigned grp, sub, l, idx, q, sc, mn;
        logic [7:0]  low;
        grp = (e >> 6) & 3;
        sub = (e >> 5) & 1;
        l   = e & 31;
        idx = grp * 2 + sub;
        low = blk_buf[48 + grp * 32 + l];
        q   = (sub ? low[7:4] : low[3:0]) | (((blk_buf[16 + l] >> (2 * grp + sub)) & 1) << 4);
        if (idx < 4)
        begin
            sc = blk_buf[4 + idx] & 63;
            mn = blk_buf[8 + idx] & 63;
        end
        else
        begin
            sc = (blk_buf[8 + idx] & 15) | ((blk_buf[idx] >> 6) << 4);
            mn = (blk_buf[8 + idx] >> 4) | ((blk_buf[4 + idx] >> 6) << 4);
        end
        // both products are exact, only the difference rounds
        return $itor(q) * (fp16_at(0) * $itor(sc)) - fp16_at(2) * $itor(mn);
    endfunction

    function automatic real q6_weight(int unsigned e);
        int unsigned hf, seg, l, q;
        logic [7:0]  lb;
        hf  = (e >> 7) & 1;
        seg = (e >> 5) & 3;
        l   = e & 31;
        lb  = blk_buf[hf * 64 + (seg & 1) * 32 + l];
        q   = (seg < 2 ? lb[3:0] : lb[7:4]) | (((blk_buf[128 + hf * 32 + l] >> (2 * seg)) & 3) << 4);
        return ($itor(q) - 32.0)
               * (fp16_at(208) * int8_value(blk_buf[192 + hf * 8 + (l >> 4) + seg * 2]));
    endfunction

    // take one accepted byte; a completed block queues its weight groups
    task automatic absorb_byte(logic [7:0] b);
        int unsigned   blk_size, elems, groups, rows;
        bit            row_done;
        weight_group_t grp;
        real           w;
        blk_size = (cur_fmt == FMT_Q5_K) ? 176 : (cur_fmt == FMT_Q6_K) ? 210 : 34;
        elems    = (cur_fmt == FMT_Q5_K || cur_fmt == FMT_Q6_K) ? 256 : 32;
        rows     = (cur_rows == 0) ? 1 : (cur_rows > ROW_BLOCKS_MAX) ? 4096 : cur_rows;
        blk_buf[fill_pos] = b;
        fill_pos++;
        if (fill_pos < blk_size)
            return;
        fill_pos = 0;
        groups   = elems / 8;
        row_done = (blk_num + 1 >= rows);
        for (int g = 0; g < groups; g++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                if (cur_fmt == FMT_Q5_K)
                    w = q5_weight(g * 8 + j);
                else if (cur_fmt == FMT_Q6_K)
                    w = q6_weight(g * 8 + j);
                else
                    w = int8_value(blk_buf[2 + g * 8 + j]) * fp16_at(0);
                grp.lane[j] = fp32_bits(w);
            end
            grp.index     = 20'(blk_num * elems + g * 8);
            grp.block_end = (g + 1 == groups);
            grp.row_end   = (g + 1 == groups) && row_done;
            expected_groups.push_back(grp);
        end
        blk_num = row_done ? 12'd0 : blk_num + 12'd1;
    endtask

    // register write, predictor follows at the same edge; any write restarts the row
    task automatic write_reg(logic [0:0] idx, logic [12:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_QUANT_FORMAT)
            cur_fmt = val[1:0];
        else
            cur_rows = val;
        fill_pos = 0;
        blk_num  = 12'd0;
    endtask

    // queue one block of random content, optionally forcing the first fp16 scale
    task automatic queue_block(int unsigned nbytes, bit force_d, logic [15:0] d);
        logic [7:0] v;
        for (int i = 0; i < nbytes; i++)
        begin
            v = 8'($urandom_range(0, 255));
            if (force_d && i == 0)
                v = d[7:0];
            if (force_d && i == 1)
                v = d[15:8];
            pending_bytes.push_back(v);
        end
    endtask

    // hold until every byte has gone in and every group has come out
    task automatic drain();
        wait (pending_bytes.size() == 0 && !in_valid && expected_groups.size() == 0);
        // decode of a partial block never happens, so a short settle is enough
        repeat (40) @(posedge clk);
    endtask

    task automatic run_phase(logic [1:0] fmt, logic [12:0] rows, int nblocks, bit fast);
        int unsigned sz;
        write_reg(REG_QUANT_FORMAT, 13'(fmt));
        write_reg(REG_ROW_BLOCKS, rows);
        sz = (fmt == FMT_Q5_K) ? 176 : (fmt == FMT_Q6_K) ? 210 : 34;
        no_idle = fast;
        for (int k = 0; k < nblocks; k++)
            queue_block(sz, 1'b0, 16'd0);
        drain();
        no_idle = 1'b0;
    endtask

    // driver: one byte transaction at a time, random gap after each unless no_idle is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            packed_byte <= 8'd0;
            tx_gap      <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_byte(packed_byte);
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    in_valid    <= 1'b1;
                    packed_byte <= pending_bytes.pop_front();
                    tx_gap      <= no_idle ? 0 : $urandom_range(0, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        weight_group_t want;
        logic [31:0]   got [8];
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            rx_gap         <= 0;
            hold_left      <= 0;
            long_hold_used <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7};
                if (expected_groups.size() == 0)
                begin
                    $error("unexpected group at element_index %0d", element_index);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_groups.pop_front();
                    for (int j = 0; j < 8; j++)
                        if (got[j] !== want.lane[j])
                        begin
                            $error("lane_%0d expected %h actual %h", j, want.lane[j], got[j]);
                            mismatch_count++;
                        end
                    if (element_index !== want.index)
                    begin
                        $error("element_index expected %0d actual %0d", want.index, element_index);
                        mismatch_count++;
                    end
                    if (last_of_block !== want.block_end)
                    begin
                        $error("last_of_block expected %b actual %b", want.block_end, last_of_block);
                        mismatch_count++;
                    end
                    if (last_of_row !== want.row_end)
                    begin
                        $error("last_of_row expected %b actual %b", want.row_end, last_of_row);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_req && !long_hold_used && out_valid)
            begin
                // sender keeps offering bytes while results back up
                long_hold_used <= 1'b1;
                hold_left      <= 600;
                out_ready      <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap    <= rx_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    rx_gap <= no_idle ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_QUANT_FORMAT;
        cfg_data       = 13'd0;
        no_idle        = 1'b0;
        long_hold_req  = 1'b0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        fill_pos       = 0;
        blk_num        = 12'd0;
        cur_fmt        = FMT_Q8_0;
        cur_rows       = 13'd1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset settings, infinite, subnormal, negative-zero and NaN scales
        queue_block(34, 1'b1, 16'h7C00);
        drain();
        write_reg(REG_ROW_BLOCKS, 13'd2);
        queue_block(34, 1'b1, 16'h0001);
        queue_block(34, 1'b1, 16'h8000);
        // abandoned partial block, the register write restarts the row
        queue_block(10, 1'b0, 16'd0);
        drain();
        write_reg(REG_QUANT_FORMAT, 13'(FMT_Q8_0));
        queue_block(34, 1'b1, 16'hFC00);
        queue_block(34, 1'b1, 16'h7E00);
        drain();

        // random rows through every format and row length extreme
        run_phase(FMT_Q5_K, 13'd2, 1, 1'b0);
        long_hold_req = 1'b1;
        run_phase(FMT_Q8_0, 13'd3, 3, 1'b0);
        run_phase(2'd3, 13'd0, 1, 1'b1);
        run_phase(FMT_Q8_0, 13'd8191, 1, 1'b1);
        run_phase(FMT_Q6_K, 13'd2, 1, 1'b0);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/qbd_pkg.sv
rtl/quantized_block_dequantizer.sv
verif/testbench.sv
